// ===== src/trsg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package trsg_pkg;

    localparam int TRSG_QUEUE_DEPTH = 32;

    localparam int TRSG_CFG_IDX_W = 3;
    localparam logic [TRSG_CFG_IDX_W-1:0] CFG_IF_CODE       = 3'd0;
    localparam logic [TRSG_CFG_IDX_W-1:0] CFG_INVERT_IF     = 3'd1;
    localparam logic [TRSG_CFG_IDX_W-1:0] CFG_CRYSTAL_CODE  = 3'd2;
    localparam logic [TRSG_CFG_IDX_W-1:0] CFG_CLK_OUT_EN    = 3'd3;
    localparam logic [TRSG_CFG_IDX_W-1:0] CFG_CLK_OUT_AMP   = 3'd4;
    localparam logic [TRSG_CFG_IDX_W-1:0] CFG_IF_DIFF_LEVEL = 3'd5;

    localparam logic [1:0] OP_TUNE  = 2'd0;
    localparam logic [1:0] OP_WAKE  = 2'd1;
    localparam logic [1:0] OP_SLEEP = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] MODE_CABLE = 2'd3;
    localparam logic [1:0] BW_KEEP    = 2'd3;

    // run layout: init table in cable layout, then the RF-tune table
    localparam logic [4:0] IDX_CABLE_FIRST = 5'd4;
    localparam logic [4:0] IDX_AFTER_CABLE = 5'd7;
    localparam logic [4:0] INIT_LEN        = 5'd19;
    localparam logic [3:0] TUNE_BW         = 4'd1;
    localparam logic [3:0] TUNE_WORD_LO    = 4'd2;
    localparam logic [3:0] TUNE_WORD_HI    = 4'd3;
    localparam logic [3:0] TUNE_BAND       = 4'd8;
    localparam logic [3:0] TUNE_LAST       = 4'd9;

    localparam logic [29:0] HIGH_BAND_HZ = 30'd333000000;
    localparam logic [4:0]  FREQ_INT_STEPS = 5'd11;
    localparam logic [4:0]  FREQ_LAST_STEP = 5'd17;

    typedef enum logic {
        GEN_IDLE,
        GEN_RUN
    } t_gen_state;

    typedef struct packed {
        logic [3:0] if_code;
        logic       invert_if;
        logic [3:0] crystal_code;
        logic       clock_out_enable;
        logic [2:0] clock_out_amplitude;
        logic [7:0] if_diff_level;
    } t_cfg;

    typedef struct packed {
        logic [7:0] addr;
        logic [7:0] value;
        logic       last;
    } t_item;

    function automatic logic [7:0] init_addr(input logic [4:0] idx);
        case (idx)
            5'd0:  init_addr = 8'h02;
            5'd1:  init_addr = 8'h03;
            5'd2:  init_addr = 8'h05;
            5'd3:  init_addr = 8'h06;
            5'd4:  init_addr = 8'h09;
            5'd5:  init_addr = 8'h0a;
            5'd6:  init_addr = 8'h0b;
            5'd7:  init_addr = 8'h2e;
            5'd8:  init_addr = 8'h30;
            5'd9:  init_addr = 8'h45;
            5'd10: init_addr = 8'h48;
            5'd11: init_addr = 8'h52;
            5'd12: init_addr = 8'h53;
            5'd13: init_addr = 8'h6a;
            5'd14: init_addr = 8'h76;
            5'd15: init_addr = 8'h78;
            5'd16: init_addr = 8'h7a;
            5'd17: init_addr = 8'h85;
            5'd18: init_addr = 8'h01;
            default: init_addr = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] init_val(input logic [4:0] idx);
        case (idx)
            5'd0:  init_val = 8'h06;
            5'd1:  init_val = 8'h48;
            5'd2:  init_val = 8'h04;
            5'd3:  init_val = 8'h10;
            5'd4:  init_val = 8'h3f;
            5'd5:  init_val = 8'h3f;
            5'd6:  init_val = 8'h3f;
            5'd7:  init_val = 8'h15;
            5'd8:  init_val = 8'h10;
            5'd9:  init_val = 8'h58;
            5'd10: init_val = 8'h19;
            5'd11: init_val = 8'h03;
            5'd12: init_val = 8'h44;
            5'd13: init_val = 8'h4b;
            5'd14: init_val = 8'h00;
            5'd15: init_val = 8'h18;
            5'd16: init_val = 8'h17;
            5'd17: init_val = 8'h06;
            5'd18: init_val = 8'h01;
            default: init_val = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] tune_addr(input logic [3:0] idx);
        case (idx)
            4'd0: tune_addr = 8'h0f;
            4'd1: tune_addr = 8'h0c;
            4'd2: tune_addr = 8'h0d;
            4'd3: tune_addr = 8'h0e;
            4'd4: tune_addr = 8'h1f;
            4'd5: tune_addr = 8'h20;
            4'd6: tune_addr = 8'h21;
            4'd7: tune_addr = 8'h22;
            4'd8: tune_addr = 8'h80;
            4'd9: tune_addr = 8'h0f;
            default: tune_addr = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] tune_val(input logic [3:0] idx);
        case (idx)
            4'd0: tune_val = 8'h00;
            4'd1: tune_val = 8'h15;
            4'd2: tune_val = 8'h40;
            4'd3: tune_val = 8'h0e;
            4'd4: tune_val = 8'h87;
            4'd5: tune_val = 8'h1f;
            4'd6: tune_val = 8'h87;
            4'd7: tune_val = 8'h1f;
            4'd8: tune_val = 8'h01;
            4'd9: tune_val = 8'h01;
            default: tune_val = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] bw_bits(input logic [1:0] bw);
        case (bw)
            2'd0: bw_bits = 8'h15;
            2'd1: bw_bits = 8'h2a;
            2'd2: bw_bits = 8'h3f;
            default: bw_bits = 8'h15;
        endcase
    endfunction

    // divisor per step: integer MHz digits, then the halving fraction steps,
    // then the final rounding threshold
    function automatic logic [29:0] freq_step_div(input logic [4:0] step);
        case (step)
            5'd0:  freq_step_div = 30'd1024000000;
            5'd1:  freq_step_div = 30'd512000000;
            5'd2:  freq_step_div = 30'd256000000;
            5'd3:  freq_step_div = 30'd128000000;
            5'd4:  freq_step_div = 30'd64000000;
            5'd5:  freq_step_div = 30'd32000000;
            5'd6:  freq_step_div = 30'd16000000;
            5'd7:  freq_step_div = 30'd8000000;
            5'd8:  freq_step_div = 30'd4000000;
            5'd9:  freq_step_div = 30'd2000000;
            5'd10: freq_step_div = 30'd1000000;
            5'd11: freq_step_div = 30'd500000;
            5'd12: freq_step_div = 30'd250000;
            5'd13: freq_step_div = 30'd125000;
            5'd14: freq_step_div = 30'd62500;
            5'd15: freq_step_div = 30'd31250;
            5'd16: freq_step_div = 30'd15625;
            5'd17: freq_step_div = 30'd7812;
            default: freq_step_div = 30'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== src/trsg_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module trsg_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ===== src/trsg_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module trsg_queue #(
    parameter int DEPTH = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire trsg_pkg::t_item i_push_item,
    output logic                o_full,
    output logic                o_valid,
    output trsg_pkg::t_item     o_item,
    input  wire logic           i_ready
);
    import trsg_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $bits(t_item);

    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          r_pend, n_pend;
    logic          r_out_valid, n_out_valid;
    t_item         r_out_item;
    logic [IW-1:0] rd_data;
    logic          rd_en;
    logic          load;

    trsg_ram #(
        .WIDTH(IW),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (i_push),
        .i_wr_addr(r_wr_ptr),
        .i_wr_data(i_push_item),
        .i_rd_en  (rd_en),
        .i_rd_addr(r_rd_ptr),
        .o_rd_data(rd_data)
    );

    always_comb begin
        // the read register holds its item until the output stage frees up
        load     = r_pend && (!r_out_valid || i_ready);
        rd_en    = (r_count != '0) && (!r_pend || load);
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count     = r_count + CW'(i_push) - CW'(rd_en);
        n_pend      = rd_en ? 1'b1 : (load ? 1'b0 : r_pend);
        n_out_valid = load ? 1'b1 : (i_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_item <= t_item'(rd_data);
        end
    end

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

endmodule
`default_nettype wire

// ===== src/trsg_freq.sv =====
`timescale 1ns / 1ps
`default_nettype none
module trsg_freq (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [29:0] i_freq,
    output logic             o_done,
    output logic      [15:0] o_word,
    output logic             o_high_band
);
    import trsg_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_step;
    logic [29:0] r_rem;
    logic [15:0] r_word;
    logic        r_high_band;
    logic [29:0] div;
    logic        take;

    always_comb begin
        div  = freq_step_div(r_step);
        // integer digits take on equal, fraction steps only on strictly greater
        take = (r_step < FREQ_INT_STEPS) ? (r_rem >= div) : (r_rem > div);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == FREQ_LAST_STEP) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem       <= i_freq;
            r_word      <= '0;
            r_high_band <= (i_freq >= HIGH_BAND_HZ);
        end else if (r_busy) begin
            if (take) begin
                r_rem <= r_rem - div;
            end
            if (r_step == FREQ_LAST_STEP) begin
                r_word <= r_word + 16'(take);
            end else begin
                r_word <= {r_word[14:0], take};
            end
        end
    end

    assign o_done      = r_done;
    assign o_word      = r_word;
    assign o_high_band = r_high_band;

endmodule
`default_nettype wire

// ===== src/trsg_gen.sv =====
`timescale 1ns / 1ps
`default_nettype none
module trsg_gen (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire trsg_pkg::t_cfg i_cfg,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [1:0]     i_op,
    input  wire logic [1:0]     i_mode,
    input  wire logic [1:0]     i_bandwidth_code,
    input  wire logic [29:0]    i_rf_freq_hz,
    output logic                o_push,
    output trsg_pkg::t_item     o_item,
    input  wire logic           i_full
);
    import trsg_pkg::*;

    t_gen_state r_state, n_state;
    logic [4:0] r_idx, n_idx;
    logic [1:0] r_op;
    logic [1:0] r_mode;
    logic [1:0] r_bw;

    logic        accept;
    logic        freq_done;
    logic [15:0] freq_word;
    logic        high_band;
    logic [3:0]  tune_idx;
    logic [3:0]  nib;
    logic        cable;
    logic        needs_word;
    t_item       item;

    trsg_freq u_freq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept && (i_op == OP_TUNE)),
        .i_freq     (i_rf_freq_hz),
        .o_done     (freq_done),
        .o_word     (freq_word),
        .o_high_band(high_band)
    );

    // patch the table entry at r_idx
    always_comb begin
        tune_idx   = 4'(r_idx - INIT_LEN);
        nib        = (i_cfg.crystal_code <= 4'd13) ? i_cfg.crystal_code : 4'd4;
        cable      = (r_mode == MODE_CABLE);
        needs_word = 1'b0;
        item       = '0;
        case (r_op)
            OP_WAKE: begin
                item = '{addr: 8'h01, value: 8'h01, last: 1'b1};
            end
            OP_SLEEP: begin
                if (r_idx == 5'd0) begin
                    item = '{addr: 8'h01, value: 8'h00, last: 1'b0};
                end else begin
                    item = '{addr: 8'h0f, value: 8'h00, last: 1'b1};
                end
            end
            default: begin
                if (r_idx < INIT_LEN) begin
                    item.addr  = init_addr(r_idx);
                    item.value = init_val(r_idx);
                    case (item.addr)
                        8'h02: begin
                            if (i_cfg.if_code <= 4'd10) begin
                                item.value = {3'b000, i_cfg.invert_if,
                                    (i_cfg.if_code == 4'd0) ? 4'd0
                                                            : i_cfg.if_code + 4'd1};
                            end
                        end
                        8'h03: item.value = {nib, i_cfg.clock_out_enable,
                                             i_cfg.clock_out_amplitude};
                        8'h05: item.value = {4'h0, nib};
                        8'h06: begin
                            if (!cable) begin
                                item.value = {6'b000100, r_mode};
                            end
                        end
                        8'h09: item.value = 8'hc1;
                        8'h0a: item.value = 8'd8 - i_cfg.if_diff_level;
                        8'h0b: item.value = 8'h17;
                        default: ;
                    endcase
                end else begin
                    item.addr  = tune_addr(tune_idx);
                    item.value = tune_val(tune_idx);
                    item.last  = (tune_idx == TUNE_LAST);
                    case (tune_idx)
                        TUNE_BW: begin
                            if (r_bw != BW_KEEP) begin
                                item.value = bw_bits(r_bw);
                            end
                        end
                        TUNE_WORD_LO: begin
                            needs_word = 1'b1;
                            item.value = freq_word[7:0];
                        end
                        TUNE_WORD_HI: begin
                            needs_word = 1'b1;
                            item.value = freq_word[15:8];
                        end
                        TUNE_BAND: item.value = {1'b0, high_band, 6'b000001};
                        default: ;
                    endcase
                end
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_ready = 1'b0;
        o_push  = 1'b0;
        accept  = 1'b0;
        case (r_state)
            GEN_IDLE: begin
                o_ready = 1'b1;
                accept  = i_valid;
                if (i_valid) begin
                    n_idx = '0;
                    // an unknown command emits nothing
                    if (i_op != OP_NONE) begin
                        n_state = GEN_RUN;
                    end
                end
            end
            GEN_RUN: begin
                // hold the frequency entries until the word is ready
                if (!i_full && (!needs_word || freq_done)) begin
                    o_push = 1'b1;
                    if (item.last) begin
                        n_state = GEN_IDLE;
                    end else if (!cable && r_op == OP_TUNE &&
                                 r_idx == IDX_CABLE_FIRST - 5'd1) begin
                        // skip the cable-only entries
                        n_idx = IDX_AFTER_CABLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: n_state = GEN_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= GEN_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_op;
            r_mode <= i_mode;
            r_bw   <= i_bandwidth_code;
        end
    end

    assign o_item = item;

endmodule
`default_nettype wire

// ===== src/tuner_register_sequence_generator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Tuner register sequence generator.
// Input channel (i_valid / o_ready): one command item with op, mode,
// bandwidth code and RF frequency. Output channel (o_valid / i_ready): one
// register write (address, value, last) per item; last marks the end of a run.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): writes register
// i_cfg_index with i_cfg_data; indexes beyond the list are dropped.
// A tune emits 26 writes (29 in cable mode), wake 1, sleep 2, op 3 none.
// The sequencer pushes one write per cycle into a 32-entry queue RAM while
// the queue has room and the frequency word is ready; a write passes through
// the queue RAM, its read register and the output register, and writes leave
// one per cycle while the receiver is ready. A new command is taken once the
// previous run is in the queue. The frequency word comes from a shift-subtract
// unit that runs during the init table. A stalled receiver fills the queue
// and then holds the sequencer; nothing is lost. Synchronous reset clears the
// config registers to 0 and empties the queue.
module tuner_register_sequence_generator_core #(
    parameter int QUEUE_DEPTH = trsg_pkg::TRSG_QUEUE_DEPTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [trsg_pkg::TRSG_CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                          i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [1:0]                          i_op,
    input  wire logic [1:0]                          i_mode,
    input  wire logic [1:0]                          i_bandwidth_code,
    input  wire logic [29:0]                         i_rf_freq_hz,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic      [7:0]                          o_reg_addr,
    output logic      [7:0]                          o_reg_value,
    output logic                                     o_last
);
    import trsg_pkg::*;

    t_cfg  r_cfg;
    logic  push;
    logic  full;
    t_item gen_item;
    t_item out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IF_CODE:       r_cfg.if_code             <= i_cfg_data[3:0];
                CFG_INVERT_IF:     r_cfg.invert_if           <= i_cfg_data[0];
                CFG_CRYSTAL_CODE:  r_cfg.crystal_code        <= i_cfg_data[3:0];
                CFG_CLK_OUT_EN:    r_cfg.clock_out_enable    <= i_cfg_data[0];
                CFG_CLK_OUT_AMP:   r_cfg.clock_out_amplitude <= i_cfg_data[2:0];
                CFG_IF_DIFF_LEVEL: r_cfg.if_diff_level       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    trsg_gen u_gen (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_mode          (i_mode),
        .i_bandwidth_code(i_bandwidth_code),
        .i_rf_freq_hz    (i_rf_freq_hz),
        .o_push          (push),
        .o_item          (gen_item),
        .i_full          (full)
    );

    trsg_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_item(gen_item),
        .o_full     (full),
        .o_valid    (o_valid),
        .o_item     (out_item),
        .i_ready    (i_ready)
    );

    assign o_reg_addr  = out_item.addr;
    assign o_reg_value = out_item.value;
    assign o_last      = out_item.last;

endmodule
`default_nettype wire
